// ----- hdl/pngenc_pkg.sv -----
// ----------------------------------------------------------------------------
// pngenc_pkg
// Shared constants and helper functions for the PNG stream encoder: chunk
// codes, the PNG signature, CRC-32 byte update and big-endian byte select.
// ----------------------------------------------------------------------------
package pngenc_pkg;

    // Width of the image size registers and their write port
    localparam int DIM_W = 14;

    // Default limits on the image size
    localparam int DEF_MAX_WIDTH  = 8192;
    localparam int DEF_MAX_HEIGHT = 8192;

    // Register indexes on the configuration port
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    // CRC-32 (reflected) and Adler-32 constants
    localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;
    localparam logic [16:0] ADLER_MOD = 17'd65521;
    localparam logic [15:0] BLOCK_MAX = 16'hFFFF;

    // Chunk types and fixed header bytes
    localparam logic [31:0] IHDR_TYPE     = 32'h4948_4452;
    localparam logic [31:0] IDAT_TYPE     = 32'h4944_4154;
    localparam logic [31:0] IEND_TYPE     = 32'h4945_4E44;
    localparam logic [31:0] IHDR_DATA_LEN = 32'd13;
    localparam logic [7:0]  ZLIB_CMF      = 8'h78;
    localparam logic [7:0]  ZLIB_FLG      = 8'h01;
    localparam logic [7:0]  BIT_DEPTH     = 8'd8;
    localparam logic [7:0]  COLOUR_RGB    = 8'd2;

    localparam logic [7:0] PNG_SIG [8] = '{8'h89, 8'h50, 8'h4E, 8'h47,
                                           8'h0D, 8'h0A, 8'h1A, 8'h0A};

    // Fold one byte into a running CRC-32
    function automatic logic [31:0] crc8_update(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] x;
        x = c ^ {24'b0, b};
        for (int k = 0; k < 8; k++)
        begin
            x = x[0] ? (CRC_POLY ^ (x >> 1)) : (x >> 1);
        end
        return x;
    endfunction

    // Pick byte sel of a word, most significant first
    function automatic logic [7:0] be_byte(input logic [31:0] v, input logic [1:0] sel);
        logic [7:0] r;
        case (sel)
            2'd0:    r = v[31:24];
            2'd1:    r = v[23:16];
            2'd2:    r = v[15:8];
            default: r = v[7:0];
        endcase
        return r;
    endfunction

endpackage

// ----- hdl/pngenc_size.sv -----
// ----------------------------------------------------------------------------
// pngenc_size
// Registered chain that derives the row length, raw scanline byte count and
// IDAT chunk length from the image size registers.
// ----------------------------------------------------------------------------
module pngenc_size #(
    parameter int MAX_WIDTH  = pngenc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = pngenc_pkg::DEF_MAX_HEIGHT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [pngenc_pkg::DIM_W-1:0] image_width,
    input  logic [pngenc_pkg::DIM_W-1:0] image_height,
    output logic [$clog2(3*(((MAX_WIDTH < (1 << pngenc_pkg::DIM_W) - 1) ? MAX_WIDTH
                  : (1 << pngenc_pkg::DIM_W) - 1))+2)-1:0] row_len,
    output logic [$clog2(longint'(((MAX_HEIGHT < (1 << pngenc_pkg::DIM_W) - 1) ? MAX_HEIGHT
                  : (1 << pngenc_pkg::DIM_W) - 1)) * longint'(3*(((MAX_WIDTH
                  < (1 << pngenc_pkg::DIM_W) - 1) ? MAX_WIDTH
                  : (1 << pngenc_pkg::DIM_W) - 1))+1)+1)-1:0] raw_total,
    output logic [31:0]                  idat_len
);

    localparam int DIM_MAX = (1 << pngenc_pkg::DIM_W) - 1;
    localparam int W_EFF   = (MAX_WIDTH < DIM_MAX) ? MAX_WIDTH : DIM_MAX;
    localparam int H_EFF   = (MAX_HEIGHT < DIM_MAX) ? MAX_HEIGHT : DIM_MAX;
    localparam int TW_W    = $clog2(3*W_EFF+2);
    localparam int RAW_W   = $clog2(longint'(H_EFF) * longint'(3*W_EFF+1) + 1);

    localparam logic [15:0] BLOCK_MAX_C = pngenc_pkg::BLOCK_MAX;

    logic [TW_W-1:0]             row_len_reg;
    logic [TW_W-1:0]             row_plus_reg;
    logic [pngenc_pkg::DIM_W-1:0] height_reg;
    logic [RAW_W-1:0]            raw_reg;
    logic [31:0]                 raw_d_reg;
    logic [15:0]                 hi_reg;
    logic [16:0]                 rem_reg;
    logic [31:0]                 raw_e_reg;
    logic [16:0]                 blocks_reg;
    logic [31:0]                 len_reg;

    logic [15:0] three_w;
    logic [31:0] prod;
    logic [31:0] raw32;
    logic [16:0] rem_fix;
    logic [16:0] quot_fix;
    logic        rem_wrap;

    // Row length and raw byte count
    assign three_w = {2'b0, image_width} + {1'b0, image_width, 1'b0};
    assign prod    = 32'(height_reg) * 32'(row_plus_reg);
    assign raw32   = 32'(raw_reg);

    // Block count: x = hi*65535 + (hi + lo), one correction step
    assign rem_wrap = rem_reg >= {1'b0, BLOCK_MAX_C};
    assign rem_fix  = rem_wrap ? (rem_reg - {1'b0, BLOCK_MAX_C}) : rem_reg;
    assign quot_fix = {1'b0, hi_reg} + {16'b0, rem_wrap};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_len_reg  <= '0;
            row_plus_reg <= '0;
            height_reg   <= '0;
            raw_reg      <= '0;
            raw_d_reg    <= '0;
            hi_reg       <= '0;
            rem_reg      <= '0;
            raw_e_reg    <= '0;
            blocks_reg   <= '0;
            len_reg      <= '0;
        end
        else
        begin
            row_len_reg  <= TW_W'(three_w);
            row_plus_reg <= TW_W'(three_w + 16'd1);
            height_reg   <= image_height;
            raw_reg      <= RAW_W'(prod);
            raw_d_reg    <= raw32;
            hi_reg       <= raw32[31:16];
            rem_reg      <= {1'b0, raw32[31:16]} + {1'b0, raw32[15:0]};
            raw_e_reg    <= raw_d_reg;
            blocks_reg   <= quot_fix + {16'b0, (rem_fix != 17'd0)};
            len_reg      <= raw_e_reg + 32'd6 + {13'b0, blocks_reg, 2'b0}
                            + {15'b0, blocks_reg};
        end
    end

    assign row_len   = row_len_reg;
    assign raw_total = raw_reg;
    assign idat_len  = len_reg;

endmodule

// ----- hdl/uncompressed_png_stream_encoder.sv -----
// ----------------------------------------------------------------------------
// uncompressed_png_stream_encoder
// RGB8 raster bytes in, complete PNG file (stored deflate) out, one byte a
// cycle while the output is not stalled.
// ----------------------------------------------------------------------------
// Path: each accepted item is held in the item register, and every byte it
//   causes is registered in the output register.
// Throughput: one file byte per cycle while the output is not stalled; an item
//   causes 1 byte for most, 2 at a row start, 5 more at a block boundary, 43
//   more for the first item of a file and 20 more for the last.
// Reset: clears the byte sequencer and checksums, image size 1 x 1.
// ----------------------------------------------------------------------------
module uncompressed_png_stream_encoder #(
    parameter int MAX_WIDTH  = pngenc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = pngenc_pkg::DEF_MAX_HEIGHT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [pngenc_pkg::DIM_W-1:0] cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [7:0]                   pixel_component,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [7:0]                   file_byte,
    output logic                         run_last,
    output logic                         file_done
);

    localparam int DIM_MAX = (1 << pngenc_pkg::DIM_W) - 1;
    localparam int W_EFF   = (MAX_WIDTH < DIM_MAX) ? MAX_WIDTH : DIM_MAX;
    localparam int H_EFF   = (MAX_HEIGHT < DIM_MAX) ? MAX_HEIGHT : DIM_MAX;
    localparam int TW_W    = $clog2(3*W_EFF+2);
    localparam int RAW_W   = $clog2(longint'(H_EFF) * longint'(3*W_EFF+1) + 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_SIG, ST_IHDR_LEN, ST_IHDR, ST_IHDR_CRC, ST_IDAT_LEN, ST_IDAT_HDR,
        ST_BLK, ST_RAW, ST_ADLER, ST_DCRC, ST_IEND_LEN, ST_IEND, ST_IEND_CRC
    } state_t;

    // Registers
    logic [pngenc_pkg::DIM_W-1:0] width_reg, width_next;
    logic [pngenc_pkg::DIM_W-1:0] height_reg, height_next;
    logic                         item_valid_reg, item_valid_next;
    logic [7:0]                   item_px_reg, item_px_next;
    state_t                       state_reg, state_next;
    logic [4:0]                   idx_reg, idx_next;
    logic                         filt_reg, filt_next;
    logic                         header_sent_reg, header_sent_next;
    logic [31:0]                  crc_reg, crc_next;
    logic [15:0]                  adler_low_reg, adler_low_next;
    logic [15:0]                  adler_high_reg, adler_high_next;
    logic [TW_W-1:0]              col_reg, col_next;
    logic [15:0]                  block_left_reg, block_left_next;
    logic [RAW_W-1:0]             raw_left_reg, raw_left_next;
    logic                         out_valid_reg, out_valid_next;
    logic [7:0]                   file_byte_reg, file_byte_next;
    logic                         run_last_reg, run_last_next;
    logic                         file_done_reg, file_done_next;

    // Size chain outputs
    logic [TW_W-1:0]  row_len;
    logic [RAW_W-1:0] raw_total;
    logic [31:0]      idat_len;

    // Sequencer signals
    state_t      eff_state;
    logic        eff_filt;
    logic [4:0]  idx;
    logic        out_ready;
    logic        adv;
    logic [7:0]  cur_byte;
    logic        cur_last;
    logic        crc_en;
    logic        item_done;
    logic        is_file_end;
    logic [31:0] raw32;
    logic        blk_final;
    logic [15:0] blk_n;
    logic [16:0] low_sum;
    logic [15:0] low_mod;
    logic [16:0] high_sum;
    logic [15:0] high_mod;
    logic [TW_W-1:0] col_inc;
    logic [pngenc_pkg::DIM_W-1:0] cfg_val;

    pngenc_size #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_size (
        .clk          (clk),
        .rst_n        (rst_n),
        .image_width  (width_reg),
        .image_height (height_reg),
        .row_len      (row_len),
        .raw_total    (raw_total),
        .idat_len     (idat_len)
    );

    // Handshake
    assign out_ready = !out_valid_reg || !out_stall;
    assign adv       = item_valid_reg && out_ready;
    assign in_stall  = item_valid_reg && !item_done;

    // Position of the byte to emit; an idle sequencer starts the held item
    always_comb
    begin
        if (state_reg == ST_IDLE)
        begin
            idx      = 5'd0;
            eff_filt = (col_reg == '0);
            if (!header_sent_reg)
                eff_state = ST_SIG;
            else if (block_left_reg == 16'd0)
                eff_state = ST_BLK;
            else
                eff_state = ST_RAW;
        end
        else
        begin
            idx       = idx_reg;
            eff_filt  = filt_reg;
            eff_state = state_reg;
        end
    end

    // Stored block header length
    assign raw32     = 32'(raw_left_reg);
    assign blk_final = raw32 <= 32'(pngenc_pkg::BLOCK_MAX);
    assign blk_n     = blk_final ? raw32[15:0] : pngenc_pkg::BLOCK_MAX;

    // Select the byte
    always_comb
    begin
        cur_byte = 8'd0;
        cur_last = (idx[1:0] == 2'd3);
        crc_en   = 1'b0;
        case (eff_state)
            ST_SIG:
            begin
                cur_byte = pngenc_pkg::PNG_SIG[idx[2:0]];
                cur_last = (idx == 5'd7);
            end
            ST_IHDR_LEN:
                cur_byte = pngenc_pkg::be_byte(pngenc_pkg::IHDR_DATA_LEN, idx[1:0]);
            ST_IHDR:
            begin
                crc_en   = 1'b1;
                cur_last = (idx == 5'd16);
                case (idx) inside
                    [5'd0:5'd3]:   cur_byte = pngenc_pkg::be_byte(pngenc_pkg::IHDR_TYPE,
                                                                  idx[1:0]);
                    [5'd4:5'd7]:   cur_byte = pngenc_pkg::be_byte(32'(width_reg), idx[1:0]);
                    [5'd8:5'd11]:  cur_byte = pngenc_pkg::be_byte(32'(height_reg), idx[1:0]);
                    5'd12:         cur_byte = pngenc_pkg::BIT_DEPTH;
                    5'd13:         cur_byte = pngenc_pkg::COLOUR_RGB;
                    default:       cur_byte = 8'd0;
                endcase
            end
            ST_IHDR_CRC, ST_DCRC, ST_IEND_CRC:
                cur_byte = pngenc_pkg::be_byte(~crc_reg, idx[1:0]);
            ST_IDAT_LEN:
                cur_byte = pngenc_pkg::be_byte(idat_len, idx[1:0]);
            ST_IDAT_HDR:
            begin
                crc_en   = 1'b1;
                cur_last = (idx == 5'd5);
                case (idx) inside
                    [5'd0:5'd3]: cur_byte = pngenc_pkg::be_byte(pngenc_pkg::IDAT_TYPE,
                                                                idx[1:0]);
                    5'd4:        cur_byte = pngenc_pkg::ZLIB_CMF;
                    default:     cur_byte = pngenc_pkg::ZLIB_FLG;
                endcase
            end
            ST_BLK:
            begin
                crc_en   = 1'b1;
                cur_last = (idx == 5'd4);
                case (idx)
                    5'd0:    cur_byte = {7'b0, blk_final};
                    5'd1:    cur_byte = blk_n[7:0];
                    5'd2:    cur_byte = blk_n[15:8];
                    5'd3:    cur_byte = ~blk_n[7:0];
                    default: cur_byte = ~blk_n[15:8];
                endcase
            end
            ST_RAW:
            begin
                crc_en   = 1'b1;
                cur_last = 1'b1;
                cur_byte = eff_filt ? 8'd0 : item_px_reg;
            end
            ST_ADLER:
            begin
                crc_en   = 1'b1;
                cur_byte = pngenc_pkg::be_byte({adler_high_reg, adler_low_reg}, idx[1:0]);
            end
            ST_IEND_LEN:
                cur_byte = 8'd0;
            ST_IEND:
            begin
                crc_en   = 1'b1;
                cur_byte = pngenc_pkg::be_byte(pngenc_pkg::IEND_TYPE, idx[1:0]);
            end
            default:
                cur_byte = 8'd0;
        endcase
    end

    // Adler-32 step over a raw byte
    assign low_sum  = {1'b0, adler_low_reg} + {9'b0, cur_byte};
    assign low_mod  = (low_sum >= pngenc_pkg::ADLER_MOD)
                      ? 16'(low_sum - pngenc_pkg::ADLER_MOD) : low_sum[15:0];
    assign high_sum = {1'b0, adler_high_reg} + {1'b0, low_mod};
    assign high_mod = (high_sum >= pngenc_pkg::ADLER_MOD)
                      ? 16'(high_sum - pngenc_pkg::ADLER_MOD) : high_sum[15:0];

    assign col_inc     = col_reg + TW_W'(1);
    assign is_file_end = (eff_state == ST_IEND_CRC) && cur_last;
    assign item_done   = adv && (is_file_end ||
                         ((eff_state == ST_RAW) && !eff_filt
                          && (raw_left_reg != RAW_W'(1))));

    // Clamp a written size value
    always_comb
    begin
        cfg_val = (cfg_data == '0) ? pngenc_pkg::DIM_W'(1) : cfg_data;
        if (cfg_index == pngenc_pkg::REG_IMAGE_WIDTH)
        begin
            if (32'(cfg_val) > MAX_WIDTH)
                cfg_val = pngenc_pkg::DIM_W'(MAX_WIDTH);
        end
        else
        begin
            if (32'(cfg_val) > MAX_HEIGHT)
                cfg_val = pngenc_pkg::DIM_W'(MAX_HEIGHT);
        end
    end

    // Next state
    always_comb
    begin
        width_next       = width_reg;
        height_next      = height_reg;
        item_valid_next  = item_valid_reg;
        item_px_next     = item_px_reg;
        state_next       = state_reg;
        idx_next         = idx_reg;
        filt_next        = filt_reg;
        header_sent_next = header_sent_reg;
        crc_next         = crc_reg;
        adler_low_next   = adler_low_reg;
        adler_high_next  = adler_high_reg;
        col_next         = col_reg;
        block_left_next  = block_left_reg;
        raw_left_next    = raw_left_reg;
        out_valid_next   = out_valid_reg;
        file_byte_next   = file_byte_reg;
        run_last_next    = run_last_reg;
        file_done_next   = file_done_reg;

        // Take size writes between files
        if (cfg_we && !header_sent_reg)
        begin
            if (cfg_index == pngenc_pkg::REG_IMAGE_WIDTH)
                width_next = cfg_val;
            else
                height_next = cfg_val;
        end

        // Hold or release the item register
        if (item_done)
            item_valid_next = 1'b0;
        if (in_valid && !in_stall)
        begin
            item_valid_next = 1'b1;
            item_px_next    = pixel_component;
        end

        // Load the output register
        if (out_ready)
        begin
            out_valid_next = adv;
            file_byte_next = cur_byte;
            run_last_next  = item_done;
            file_done_next = is_file_end;
        end

        // Advance the sequencer
        if (adv)
        begin
            filt_next  = eff_filt;
            state_next = eff_state;
            idx_next   = cur_last ? 5'd0 : idx + 5'd1;
            if (crc_en)
                crc_next = pngenc_pkg::crc8_update(crc_reg, cur_byte);
            if (cur_last)
            begin
                case (eff_state)
                    ST_SIG:      state_next = ST_IHDR_LEN;
                    ST_IHDR_LEN: state_next = ST_IHDR;
                    ST_IHDR:     state_next = ST_IHDR_CRC;
                    ST_IHDR_CRC:
                    begin
                        state_next = ST_IDAT_LEN;
                        crc_next   = pngenc_pkg::CRC_INIT;
                    end
                    ST_IDAT_LEN: state_next = ST_IDAT_HDR;
                    ST_IDAT_HDR:
                    begin
                        state_next       = ST_BLK;
                        header_sent_next = 1'b1;
                        raw_left_next    = raw_total;
                        block_left_next  = 16'd0;
                        col_next         = '0;
                        filt_next        = 1'b1;
                    end
                    ST_BLK:
                    begin
                        state_next      = ST_RAW;
                        block_left_next = blk_n;
                    end
                    ST_RAW:
                    begin
                        adler_low_next  = low_mod;
                        adler_high_next = high_mod;
                        block_left_next = block_left_reg - 16'd1;
                        raw_left_next   = raw_left_reg - RAW_W'(1);
                        if (eff_filt)
                        begin
                            filt_next  = 1'b0;
                            state_next = (block_left_reg == 16'd1) ? ST_BLK : ST_RAW;
                        end
                        else
                        begin
                            col_next   = (col_inc >= row_len) ? '0 : col_inc;
                            state_next = (raw_left_reg == RAW_W'(1)) ? ST_ADLER : ST_IDLE;
                        end
                    end
                    ST_ADLER:    state_next = ST_DCRC;
                    ST_DCRC:
                    begin
                        state_next = ST_IEND_LEN;
                        crc_next   = pngenc_pkg::CRC_INIT;
                    end
                    ST_IEND_LEN: state_next = ST_IEND;
                    ST_IEND:     state_next = ST_IEND_CRC;
                    ST_IEND_CRC:
                    begin
                        // Drop back to a fresh file
                        state_next       = ST_IDLE;
                        crc_next         = pngenc_pkg::CRC_INIT;
                        adler_low_next   = 16'd1;
                        adler_high_next  = 16'd0;
                        col_next         = '0;
                        block_left_next  = 16'd0;
                        raw_left_next    = '0;
                        header_sent_next = 1'b0;
                    end
                    default:     state_next = ST_IDLE;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg       <= pngenc_pkg::DIM_W'(1);
            height_reg      <= pngenc_pkg::DIM_W'(1);
            item_valid_reg  <= 1'b0;
            state_reg       <= ST_IDLE;
            idx_reg         <= 5'd0;
            filt_reg        <= 1'b0;
            header_sent_reg <= 1'b0;
            crc_reg         <= pngenc_pkg::CRC_INIT;
            adler_low_reg   <= 16'd1;
            adler_high_reg  <= 16'd0;
            col_reg         <= '0;
            block_left_reg  <= 16'd0;
            raw_left_reg    <= '0;
            out_valid_reg   <= 1'b0;
            run_last_reg    <= 1'b0;
            file_done_reg   <= 1'b0;
        end
        else
        begin
            width_reg       <= width_next;
            height_reg      <= height_next;
            item_valid_reg  <= item_valid_next;
            state_reg       <= state_next;
            idx_reg         <= idx_next;
            filt_reg        <= filt_next;
            header_sent_reg <= header_sent_next;
            crc_reg         <= crc_next;
            adler_low_reg   <= adler_low_next;
            adler_high_reg  <= adler_high_next;
            col_reg         <= col_next;
            block_left_reg  <= block_left_next;
            raw_left_reg    <= raw_left_next;
            out_valid_reg   <= out_valid_next;
            run_last_reg    <= run_last_next;
            file_done_reg   <= file_done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        item_px_reg   <= item_px_next;
        file_byte_reg <= file_byte_next;
    end

    assign out_valid = out_valid_reg;
    assign file_byte = file_byte_reg;
    assign run_last  = run_last_reg;
    assign file_done = file_done_reg;

    // Checks
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && file_done_reg |-> run_last_reg)
        else $error("file end byte not marked as last of its item");

    a_file_clears: assert property (@(posedge clk) disable iff (!rst_n)
        adv && is_file_end |=> !header_sent_reg && (state_reg == ST_IDLE))
        else $error("state not cleared after file end");

    a_raw_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RAW) |-> (raw_left_reg != '0) && (block_left_reg != 16'd0))
        else $error("raw byte with no bytes left in stream or block");

    a_busy_holds_item: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> item_valid_reg)
        else $error("sequencer running without an item");

endmodule

// ----- tb/uncompressed_png_stream_encoder_tb.sv -----
// ----------------------------------------------------------------------------
// uncompressed_png_stream_encoder_tb
// Self-checking bench for the PNG stream encoder. RGB bytes are fed in raster
// order with random bursts and gaps while the output side stalls at random.
// A local encoder model predicts up to 50 file bytes per component with frame
// flags; each accepted output word is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module uncompressed_png_stream_encoder_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          MAX_W       = pngenc_pkg::DEF_MAX_WIDTH;
    localparam int          MAX_H       = pngenc_pkg::DEF_MAX_HEIGHT;
    localparam int          SETTLE      = 8;
    localparam longint      CYCLE_LIMIT = 4000000;
    localparam logic [31:0] GF_POLY     = 32'hEDB8_8320;
    localparam int unsigned ADLER_BASE  = 65521;
    localparam int unsigned STORED_MAX  = 65535;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       done;
    } png_word_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        cfg_we = 1'b0;
    logic                        cfg_index = 1'b0;
    logic [pngenc_pkg::DIM_W-1:0] cfg_data = '0;
    logic                        in_valid = 1'b0;
    logic                        in_stall;
    logic [7:0]                  pixel_component = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic [7:0]                  file_byte;
    logic                        run_last;
    logic                        file_done;

    // Encoder model state
    int unsigned cur_width = 1;
    int unsigned cur_height = 1;
    logic [31:0] idat_crc;
    logic [15:0] sum_low;
    logic [15:0] sum_high;
    int unsigned col_bytes;
    int unsigned rows_done;
    int unsigned block_left;
    int unsigned scan_left;
    bit          in_file;

    png_word_t   item_words[$];
    png_word_t   file_bytes_due[$];

    // Traffic shaping and bookkeeping
    int          gap_max = 0;
    int          stall_pct = 0;
    int          burst_left = 0;
    longint      cycle_count = 0;
    int          fail_count = 0;
    int          items_sent = 0;
    int          files_done = 0;
    longint      words_checked = 0;

    uncompressed_png_stream_encoder uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .pixel_component (pixel_component),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .file_byte       (file_byte),
        .run_last        (run_last),
        .file_done       (file_done)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Encoder model
    // ------------------------------------------------------------------------
    function automatic logic [31:0] gf_crc_step(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] x;
        x = c ^ {24'b0, b};
        for (int k = 0; k < 8; k++)
        begin
            x = x[0] ? (GF_POLY ^ (x >> 1)) : (x >> 1);
        end
        return x;
    endfunction

    task automatic put_word(input logic [7:0] b);
        png_word_t w;
        w.data = b;
        w.last = 1'b0;
        w.done = 1'b0;
        if (item_words.size() < 50)
            item_words = {item_words, w};
    endtask

    task automatic put_word32(input logic [31:0] v);
        put_word(v[31:24]);
        put_word(v[23:16]);
        put_word(v[15:8]);
        put_word(v[7:0]);
    endtask

    task automatic put_idat(input logic [7:0] b);
        idat_crc = gf_crc_step(idat_crc, b);
        put_word(b);
    endtask

    // One scanline byte, opening a stored block when the previous one is used up
    task automatic put_scan(input logic [7:0] b);
        int unsigned n;
        if (block_left == 0)
        begin
            n = (scan_left < STORED_MAX) ? scan_left : STORED_MAX;
            put_idat((n == scan_left) ? 8'd1 : 8'd0);
            put_idat(n[7:0]);
            put_idat(n[15:8]);
            put_idat(~n[7:0]);
            put_idat(~n[15:8]);
            block_left = n;
        end
        put_idat(b);
        sum_low = 16'((32'(sum_low) + b) % ADLER_BASE);
        sum_high = 16'((32'(sum_high) + sum_low) % ADLER_BASE);
        if (block_left > 0)
            block_left--;
        if (scan_left > 0)
            scan_left--;
    endtask

    task automatic clear_model();
        idat_crc = 32'hFFFF_FFFF;
        sum_low = 16'd1;
        sum_high = 16'd0;
        col_bytes = 0;
        rows_done = 0;
        block_left = 0;
        scan_left = 0;
        in_file = 1'b0;
    endtask

    task automatic put_file_head();
        logic [7:0]  hdr[17];
        logic [31:0] c;
        int unsigned raw;
        int unsigned blocks;
        logic [7:0]  sig[8];
        sig = '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A};
        foreach (sig[i])
            put_word(sig[i]);
        hdr = '{8'h49, 8'h48, 8'h44, 8'h52, 8'h00, 8'h00, 8'h00, 8'h00,
                8'h00, 8'h00, 8'h00, 8'h00, 8'd8, 8'd2, 8'd0, 8'd0, 8'd0};
        {hdr[4], hdr[5], hdr[6], hdr[7]} = 32'(cur_width);
        {hdr[8], hdr[9], hdr[10], hdr[11]} = 32'(cur_height);
        put_word32(32'd13);
        c = 32'hFFFF_FFFF;
        foreach (hdr[i])
        begin
            c = gf_crc_step(c, hdr[i]);
            put_word(hdr[i]);
        end
        put_word32(~c);
        raw = cur_height * (1 + 3 * cur_width);
        blocks = raw / STORED_MAX + ((raw % STORED_MAX) != 0 ? 1 : 0);
        put_word32(32'(2 + raw + 5 * blocks + 4));
        idat_crc = 32'hFFFF_FFFF;
        put_idat(8'h49);
        put_idat(8'h44);
        put_idat(8'h41);
        put_idat(8'h54);
        put_idat(8'h78);
        put_idat(8'h01);
        scan_left = raw;
        block_left = 0;
        col_bytes = 0;
        rows_done = 0;
        sum_low = 16'd1;
        sum_high = 16'd0;
        in_file = 1'b1;
    endtask

    task automatic put_file_tail();
        logic [31:0] c;
        logic [31:0] adler;
        adler = {sum_high, sum_low};
        put_idat(adler[31:24]);
        put_idat(adler[23:16]);
        put_idat(adler[15:8]);
        put_idat(adler[7:0]);
        put_word32(~idat_crc);
        put_word32(32'd0);
        c = 32'hFFFF_FFFF;
        c = gf_crc_step(c, 8'h49); put_word(8'h49);
        c = gf_crc_step(c, 8'h45); put_word(8'h45);
        c = gf_crc_step(c, 8'h4E); put_word(8'h4E);
        c = gf_crc_step(c, 8'h44); put_word(8'h44);
        put_word32(~c);
        item_words[item_words.size() - 1].done = 1'b1;
    endtask

    // Work out the file bytes caused by one accepted component, keeping at most 50
    task automatic encode_component(input logic [7:0] px);
        item_words.delete();
        if (!in_file)
            put_file_head();
        if (col_bytes == 0)
            put_scan(8'h00);
        put_scan(px);
        col_bytes++;
        if (col_bytes >= 3 * cur_width)
        begin
            col_bytes = 0;
            rows_done++;
        end
        if (scan_left == 0)
        begin
            put_file_tail();
            clear_model();
            files_done++;
        end
        item_words[item_words.size() - 1].last = 1'b1;
        foreach (item_words[i])
            file_bytes_due = {file_bytes_due, item_words[i]};
    endtask

    task automatic apply_size_write(input logic idx, input logic [pngenc_pkg::DIM_W-1:0] val);
        int unsigned v;
        v = val;
        if (in_file)
            return;
        if (v < 1)
            v = 1;
        if (idx == pngenc_pkg::REG_IMAGE_WIDTH)
            cur_width = (v > MAX_W) ? MAX_W : v;
        else
            cur_height = (v > MAX_H) ? MAX_H : v;
    endtask

    // ------------------------------------------------------------------------
    // Output side: stall pattern and result check
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        png_word_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (file_bytes_due.size() == 0)
            begin
                $error("unexpected word: file_byte %02h", file_byte);
                fail_count++;
            end
            else
            begin
                w = file_bytes_due.pop_front();
                words_checked++;
                if (file_byte !== w.data)
                begin
                    $error("file_byte: expected %02h, got %02h", w.data, file_byte);
                    fail_count++;
                end
                if (run_last !== w.last)
                begin
                    $error("run_last: expected %0b, got %0b", w.last, run_last);
                    fail_count++;
                end
                if (file_done !== w.done)
                begin
                    $error("file_done: expected %0b, got %0b", w.done, file_done);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("uncompressed_png_stream_encoder regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    // Hold one component until accepted, then maybe open a gap
    task automatic send_component(input logic [7:0] px);
        int gap;
        pixel_component <= px;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        encode_component(px);
        items_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(1, 16);
            gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (file_bytes_due.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Pulse one register write, then leave the port idle
    task automatic write_size(input logic idx, input logic [pngenc_pkg::DIM_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        apply_size_write(idx, val);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_size(input logic [pngenc_pkg::DIM_W-1:0] w,
                            input logic [pngenc_pkg::DIM_W-1:0] h);
        drain();
        write_size(pngenc_pkg::REG_IMAGE_WIDTH, w);
        write_size(pngenc_pkg::REG_IMAGE_HEIGHT, h);
    endtask

    task automatic send_random_file();
        int n;
        n = 3 * cur_width * cur_height;
        repeat (n) send_component(8'($urandom));
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Reset size 1 x 1 with extreme byte values
    task automatic test_reset_size();
        gap_max = 0;
        stall_pct = 0;
        send_component(8'h00);
        send_component(8'hFF);
        send_component(8'h80);
        gap_max = 3;
        stall_pct = 40;
        send_component(8'h7F);
        send_component(8'h01);
        send_component(8'hFE);
    endtask

    // Two small files back to back, no register write between
    task automatic test_row_framing();
        set_size(14'd2, 14'd2);
        repeat (2)
        begin
            for (int i = 0; i < 12; i++)
                send_component((i % 2) ? 8'hFF : 8'h00);
        end
    endtask

    // A write in the middle of a file must leave its size alone
    task automatic test_write_mid_file();
        set_size(14'd2, 14'd1);
        repeat (3) send_component(8'($urandom));
        drain();
        write_size(pngenc_pkg::REG_IMAGE_WIDTH, 14'd5);
        write_size(pngenc_pkg::REG_IMAGE_HEIGHT, 14'd4);
        repeat (3) send_component(8'($urandom));
    endtask

    // Zero taken as one
    task automatic test_zero_clamp();
        set_size(14'd0, 14'd0);
        send_random_file();
        set_size(14'd3, 14'd0);
        send_random_file();
    endtask

    task automatic test_random_files();
        int budget;
        budget = 400;
        while (budget > 0)
        begin
            gap_max = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
            stall_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(10, 60);
            set_size(14'($urandom_range(1, 6)), 14'($urandom_range(1, 5)));
            budget -= 3 * cur_width * cur_height;
            send_random_file();
        end
    endtask

    initial
    begin
        clear_model();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_size();
        test_row_framing();
        test_write_mid_file();
        test_zero_clamp();
        test_random_files();
        drain();
        $display("Encoded %0d files from %0d components; %0d file bytes checked.",
                 files_done, items_sent, words_checked);
        $display("Covered 1x1 up to 6x5 images, back-to-back files, size writes and clamping.");
        if (fail_count == 0 && file_bytes_due.size() == 0)
            $display("uncompressed_png_stream_encoder regression: pass");
        else
            $display("uncompressed_png_stream_encoder regression: fail");
        $finish;
    end

endmodule
